// ===== rtl/bcrt_pkg.sv =====
// Package for the budgeted climb reach tracker.
// Holds payload structs, register indexes, widths and controller/datapath links.
// No dependencies.
package bcrt_pkg;

  localparam int HEIGHT_W       = 31;
  localparam int LADDER_W       = 5;
  localparam int IDX_OUT_W      = 16;
  localparam int CFG_DATA_W     = 31;
  localparam int CFG_IDX_W      = 1;
  localparam int BUDGET_W       = 33;
  localparam int MAX_PASSES_DEF = 16;
  localparam int INDEX_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BRICK_BUDGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LADDER_COUNT = 1'b1;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                start_req;
  } in_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] building_index;
    logic                 reachable;
    logic [IDX_OUT_W-1:0] furthest;
  } out_t;

  typedef struct packed {
    logic capture;
    logic insert;
    logic trim;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/budgeted_climb_reach_tracker.sv =====
// Budgeted climb reach tracker, top level: bcrt_ctrl sequencer plus bcrt_dpath.
// An input is accepted and captured only when idle, then passes cell-chain insert,
// trim and emit in order; emit registers the result once the output is free.
// The output register frees the input side while a result waits downstream.
// Reset (async, active low) clears all control and sequence state at once;
// no clearing pass is needed, the pass cells are read only below the fill count.
module budgeted_climb_reach_tracker
  import bcrt_pkg::*;
#(
  parameter int MAX_PASSES = MAX_PASSES_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  bcrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bcrt_dpath #(
    .MAX_PASSES (MAX_PASSES),
    .INDEX_BITS (INDEX_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/bcrt_ctrl.sv =====
// Controller for the budgeted climb reach tracker.
// Sequences capture, insert, trim and emit steps; depends on bcrt_pkg.
module bcrt_ctrl
  import bcrt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_TRIM,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_INSERT;
      S_INSERT: state_d = S_TRIM;
      S_TRIM:   state_d = S_EMIT;
      S_EMIT:   if (stat_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.insert  = (state_q == S_INSERT);
  assign cmd_o.trim    = (state_q == S_TRIM);
  assign cmd_o.emit    = (state_q == S_EMIT) && stat_i.out_free;

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.insert, cmd_o.trim, cmd_o.emit}))
    else $error("more than one command at once");

  a_insert_after_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.insert)
    else $error("insert did not follow capture");

  a_trim_after_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.insert |=> cmd_o.trim)
    else $error("trim did not follow insert");

endmodule

// ===== rtl/bcrt_dpath.sv =====
// Datapath for the budgeted climb reach tracker: sorted cell chain of free
// passes, budget, position tracking, config registers and output register.
// Depends on bcrt_pkg; driven by bcrt_ctrl commands.
module bcrt_dpath
  import bcrt_pkg::*;
#(
  parameter int MAX_PASSES = MAX_PASSES_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_t                   in_data_i,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o
);

  localparam int FW = $clog2(MAX_PASSES + 1);
  localparam int CW = (FW > LADDER_W) ? FW : LADDER_W;
  localparam int XW = INDEX_BITS + IDX_OUT_W;

  logic [HEIGHT_W-1:0]          budget_cfg_q;
  logic [LADDER_W-1:0]          ladder_q;
  logic [HEIGHT_W-1:0]          h_q;
  logic                         start_q;
  logic [HEIGHT_W-1:0]          cell_q [MAX_PASSES];
  logic [HEIGHT_W-1:0]          cell_d [MAX_PASSES];
  logic [FW-1:0]                fill_q, fill_d;
  logic signed [BUDGET_W-1:0]   budget_q, budget_d;
  logic [HEIGHT_W-1:0]          prev_q, prev_d;
  logic [INDEX_BITS-1:0]        pos_q, pos_d;
  logic [INDEX_BITS-1:0]        far_q, far_d;
  logic                         halted_q, halted_d;
  logic                         reach_q, reach_d;
  logic                         out_valid_q;
  out_t                         out_q;

  logic [HEIGHT_W-1:0]          rise;
  logic                         rise_pos;
  logic                         full;
  logic                         displace;
  logic                         pop;
  logic [CW-1:0]                limit;
  logic [CW-1:0]                ladder_x;
  logic [HEIGHT_W-1:0]          ins_c  [MAX_PASSES];
  logic [HEIGHT_W-1:0]          disp_c [MAX_PASSES];
  logic [HEIGHT_W-1:0]          nxt_c  [MAX_PASSES];
  logic [MAX_PASSES-1:0]        le;
  logic [MAX_PASSES-1:0]        sle;
  logic [MAX_PASSES-1:0]        ord;
  logic signed [BUDGET_W-1:0]   min_x;
  logic signed [BUDGET_W-1:0]   rise_x;
  logic signed [BUDGET_W-1:0]   trim_b;
  logic [XW-1:0]                pos_x;
  logic [XW-1:0]                far_x;

  assign rise     = h_q - prev_q;
  assign rise_pos = h_q > prev_q;
  assign full     = (fill_q == FW'(MAX_PASSES));
  assign displace = rise > cell_q[0];
  assign ladder_x = CW'(ladder_q);
  assign limit    = (ladder_x > CW'(MAX_PASSES)) ? CW'(MAX_PASSES) : ladder_x;
  assign pop      = CW'(fill_q) > limit;
  assign min_x    = $signed({{(BUDGET_W-HEIGHT_W){1'b0}}, cell_q[0]});
  assign rise_x   = $signed({{(BUDGET_W-HEIGHT_W){1'b0}}, rise});
  assign trim_b   = pop ? (budget_q - min_x) : budget_q;

  for (genvar i = 0; i < MAX_PASSES; i++) begin : g_cell
    assign le[i] = (FW'(i) < fill_q) && (cell_q[i] <= rise);
    if (i < MAX_PASSES - 1) begin : g_nxt
      assign nxt_c[i] = cell_q[i+1];
      assign sle[i]   = cell_q[i+1] <= rise;
    end else begin : g_last
      assign nxt_c[i] = cell_q[i];
      assign sle[i]   = 1'b0;
    end
    if (i == 0) begin : g_head
      assign ins_c[i]  = le[i] ? cell_q[i] : rise;
      assign disp_c[i] = sle[i] ? nxt_c[i] : rise;
      assign ord[i]    = 1'b1;
    end else begin : g_body
      assign ins_c[i]  = le[i] ? cell_q[i] : (le[i-1] ? rise : cell_q[i-1]);
      assign disp_c[i] = sle[i] ? nxt_c[i] : (sle[i-1] ? rise : cell_q[i]);
      assign ord[i]    = (FW'(i) >= fill_q) || (cell_q[i-1] <= cell_q[i]);
    end
  end

  always_comb begin
    cell_d   = cell_q;
    fill_d   = fill_q;
    budget_d = budget_q;
    prev_d   = prev_q;
    pos_d    = pos_q;
    far_d    = far_q;
    halted_d = halted_q;
    reach_d  = reach_q;
    if (cmd_i.insert) begin
      if (start_q) begin
        fill_d   = '0;
        budget_d = $signed({{(BUDGET_W-HEIGHT_W){1'b0}}, budget_cfg_q});
        prev_d   = h_q;
        pos_d    = '0;
        far_d    = '0;
        halted_d = 1'b0;
        reach_d  = 1'b1;
      end else begin
        if (pos_q != '1) pos_d = pos_q + 1'b1;
        prev_d = h_q;
        if (!halted_q && rise_pos) begin
          if (!full) begin
            cell_d = ins_c;
            fill_d = fill_q + 1'b1;
          end else if (displace) begin
            cell_d   = disp_c;
            budget_d = budget_q - min_x;
          end else begin
            budget_d = budget_q - rise_x;
          end
        end
      end
    end
    if (cmd_i.trim && !start_q) begin
      if (halted_q) begin
        reach_d = 1'b0;
      end else begin
        if (pop) begin
          cell_d = nxt_c;
          fill_d = fill_q - 1'b1;
        end
        budget_d = trim_b;
        if (trim_b < 0) begin
          halted_d = 1'b1;
          reach_d  = 1'b0;
        end else begin
          far_d   = pos_q;
          reach_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_cfg_q <= '0;
      ladder_q     <= '0;
      fill_q       <= '0;
      budget_q     <= '0;
      prev_q       <= '0;
      pos_q        <= '0;
      far_q        <= '0;
      halted_q     <= 1'b0;
      reach_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_BRICK_BUDGET: budget_cfg_q <= cfg_data_i;
          CFG_LADDER_COUNT: ladder_q     <= cfg_data_i[LADDER_W-1:0];
          default: ;
        endcase
      end
      fill_q   <= fill_d;
      budget_q <= budget_d;
      prev_q   <= prev_d;
      pos_q    <= pos_d;
      far_q    <= far_d;
      halted_q <= halted_d;
      reach_q  <= reach_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign pos_x = XW'(pos_q);
  assign far_x = XW'(far_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      h_q     <= in_data_i.height;
      start_q <= in_data_i.start_req;
    end
    cell_q <= cell_d;
    if (cmd_i.emit) begin
      out_q.building_index <= pos_x[IDX_OUT_W-1:0];
      out_q.reachable      <= reach_q;
      out_q.furthest       <= far_x[IDX_OUT_W-1:0];
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_PASSES))
    else $error("pass fill exceeds capacity");

  a_cells_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &ord)
    else $error("pass cells out of order");

  a_budget_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.trim |=> (halted_q || !budget_q[BUDGET_W-1]))
    else $error("negative budget without halt");

endmodule
